// File: hdl/cpu_exu_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// 6502 execute unit package
// Shared widths, operation codes, flag positions and the queue entry type.
// ----------------------------------------------------------------------------
package cpu_exu_pkg;

  // Field widths of the request and result channels.
  localparam int unsigned FuncW = 5;
  localparam int unsigned DataW = 8;
  localparam int unsigned AddrW = 16;

  // Default depth of the queue between front and back end.
  localparam int unsigned QueueDepthDefault = 2;

  // Operation codes as they arrive on the request channel.
  localparam logic [FuncW-1:0] FuncAdc    = 5'd0;
  localparam logic [FuncW-1:0] FuncAnd    = 5'd1;
  localparam logic [FuncW-1:0] FuncAslMem = 5'd2;
  localparam logic [FuncW-1:0] FuncAslAcc = 5'd3;
  localparam logic [FuncW-1:0] FuncBit    = 5'd4;
  localparam logic [FuncW-1:0] FuncCpx    = 5'd5;
  localparam logic [FuncW-1:0] FuncDec    = 5'd6;
  localparam logic [FuncW-1:0] FuncDex    = 5'd7;
  localparam logic [FuncW-1:0] FuncDey    = 5'd8;
  localparam logic [FuncW-1:0] FuncLda    = 5'd9;
  localparam logic [FuncW-1:0] FuncLdx    = 5'd10;
  localparam logic [FuncW-1:0] FuncLdy    = 5'd11;
  localparam logic [FuncW-1:0] FuncSta    = 5'd12;
  localparam logic [FuncW-1:0] FuncStx    = 5'd13;
  localparam logic [FuncW-1:0] FuncSty    = 5'd14;
  localparam logic [FuncW-1:0] FuncBrk    = 5'd15;
  localparam logic [FuncW-1:0] FuncBcc    = 5'd16;
  localparam logic [FuncW-1:0] FuncBcs    = 5'd17;
  localparam logic [FuncW-1:0] FuncBeq    = 5'd18;
  localparam logic [FuncW-1:0] FuncBmi    = 5'd19;
  localparam logic [FuncW-1:0] FuncBne    = 5'd20;
  localparam logic [FuncW-1:0] FuncBpl    = 5'd21;
  localparam logic [FuncW-1:0] FuncBvc    = 5'd22;
  localparam logic [FuncW-1:0] FuncBvs    = 5'd23;

  // Status register bit positions.
  localparam int unsigned FlagC = 0;
  localparam int unsigned FlagZ = 1;
  localparam int unsigned FlagI = 2;
  localparam int unsigned FlagB = 4;
  localparam int unsigned FlagV = 6;
  localparam int unsigned FlagN = 7;

  // Stack page and stack pointer value after reset.
  localparam logic [DataW-1:0] StackPage = 8'h01;
  localparam logic [DataW-1:0] SpReset   = 8'hFF;

  // Operation classes produced by the front end.
  typedef enum logic [4:0] {
    OP_ADC,
    OP_AND,
    OP_ASL_MEM,
    OP_SHIFT_ACC,
    OP_BIT,
    OP_CPX,
    OP_DEC,
    OP_DEX,
    OP_DEY,
    OP_LDA,
    OP_LDX,
    OP_LDY,
    OP_STA,
    OP_STX,
    OP_STY,
    OP_BRK,
    OP_BRANCH,
    OP_NOP
  } op_e;

  // Flag tested by a conditional branch.
  typedef enum logic [1:0] {
    BR_C,
    BR_Z,
    BR_N,
    BR_V
  } br_flag_e;

  // One decoded operation waiting in the queue.
  typedef struct packed {
    op_e              op;
    br_flag_e         br_flag;
    logic             br_want;
    logic [DataW-1:0] operand;
    logic [AddrW-1:0] eff_addr;
    logic [AddrW-1:0] ret_addr;
  } qent_t;

endpackage

// File: hdl/cpu_exu_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// 6502 execute unit channels
// Valid/ready interfaces for the operation requests and the result stream.
// ----------------------------------------------------------------------------
interface cpu_exu_in_if;
  logic                             valid;
  logic                             ready;
  logic [cpu_exu_pkg::FuncW-1:0]    func;
  logic [cpu_exu_pkg::DataW-1:0]    operand;
  logic [cpu_exu_pkg::AddrW-1:0]    eff_addr;
  logic [cpu_exu_pkg::AddrW-1:0]    prog_counter;

  modport source (output valid, func, operand, eff_addr, prog_counter, input ready);
  modport sink   (input valid, func, operand, eff_addr, prog_counter, output ready);
endinterface

interface cpu_exu_out_if;
  logic                             valid;
  logic                             ready;
  logic                             write_enable;
  logic [cpu_exu_pkg::AddrW-1:0]    write_addr;
  logic [cpu_exu_pkg::DataW-1:0]    write_data;
  logic [cpu_exu_pkg::DataW-1:0]    acc_value;
  logic [cpu_exu_pkg::DataW-1:0]    x_value;
  logic [cpu_exu_pkg::DataW-1:0]    y_value;
  logic [cpu_exu_pkg::DataW-1:0]    flags_value;
  logic                             branch_taken;
  logic                             vector_fetch;
  logic                             last;

  modport source (output valid, write_enable, write_addr, write_data, acc_value, x_value,
                  y_value, flags_value, branch_taken, vector_fetch, last, input ready);
  modport sink   (input valid, write_enable, write_addr, write_data, acc_value, x_value,
                  y_value, flags_value, branch_taken, vector_fetch, last, output ready);
endinterface

// File: hdl/cpu_exu_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// 6502 execute unit front end
// Accepts requests, decodes the operation code into an operation class and
// branch condition, precomputes the BRK return address and feeds the queue.
// ----------------------------------------------------------------------------
module cpu_exu_front (
  cpu_exu_in_if.sink          req_i,
  input  logic                full_i,
  output logic                push_o,
  output cpu_exu_pkg::qent_t  push_data_o
);

  // A request is taken whenever the queue has room.
  assign req_i.ready = !full_i;
  assign push_o      = req_i.valid && !full_i;

  // Operation decode.
  always_comb begin
    push_data_o.op       = cpu_exu_pkg::OP_NOP;
    push_data_o.br_flag  = cpu_exu_pkg::BR_C;
    push_data_o.br_want  = 1'b0;
    push_data_o.operand  = req_i.operand;
    push_data_o.eff_addr = req_i.eff_addr;
    // BRK pushes the address of the byte after its opcode minus one.
    push_data_o.ret_addr = req_i.prog_counter - cpu_exu_pkg::AddrW'(1);
    unique case (req_i.func)
      cpu_exu_pkg::FuncAdc:    push_data_o.op = cpu_exu_pkg::OP_ADC;
      cpu_exu_pkg::FuncAnd:    push_data_o.op = cpu_exu_pkg::OP_AND;
      cpu_exu_pkg::FuncAslMem: push_data_o.op = cpu_exu_pkg::OP_ASL_MEM;
      cpu_exu_pkg::FuncAslAcc: push_data_o.op = cpu_exu_pkg::OP_SHIFT_ACC;
      cpu_exu_pkg::FuncBit:    push_data_o.op = cpu_exu_pkg::OP_BIT;
      cpu_exu_pkg::FuncCpx:    push_data_o.op = cpu_exu_pkg::OP_CPX;
      cpu_exu_pkg::FuncDec:    push_data_o.op = cpu_exu_pkg::OP_DEC;
      cpu_exu_pkg::FuncDex:    push_data_o.op = cpu_exu_pkg::OP_DEX;
      cpu_exu_pkg::FuncDey:    push_data_o.op = cpu_exu_pkg::OP_DEY;
      cpu_exu_pkg::FuncLda:    push_data_o.op = cpu_exu_pkg::OP_LDA;
      cpu_exu_pkg::FuncLdx:    push_data_o.op = cpu_exu_pkg::OP_LDX;
      cpu_exu_pkg::FuncLdy:    push_data_o.op = cpu_exu_pkg::OP_LDY;
      cpu_exu_pkg::FuncSta:    push_data_o.op = cpu_exu_pkg::OP_STA;
      cpu_exu_pkg::FuncStx:    push_data_o.op = cpu_exu_pkg::OP_STX;
      cpu_exu_pkg::FuncSty:    push_data_o.op = cpu_exu_pkg::OP_STY;
      cpu_exu_pkg::FuncBrk:    push_data_o.op = cpu_exu_pkg::OP_BRK;
      cpu_exu_pkg::FuncBcc: begin
        push_data_o.op      = cpu_exu_pkg::OP_BRANCH;
        push_data_o.br_flag = cpu_exu_pkg::BR_C;
        push_data_o.br_want = 1'b0;
      end
      cpu_exu_pkg::FuncBcs: begin
        push_data_o.op      = cpu_exu_pkg::OP_BRANCH;
        push_data_o.br_flag = cpu_exu_pkg::BR_C;
        push_data_o.br_want = 1'b1;
      end
      cpu_exu_pkg::FuncBeq: begin
        push_data_o.op      = cpu_exu_pkg::OP_BRANCH;
        push_data_o.br_flag = cpu_exu_pkg::BR_Z;
        push_data_o.br_want = 1'b1;
      end
      cpu_exu_pkg::FuncBmi: begin
        push_data_o.op      = cpu_exu_pkg::OP_BRANCH;
        push_data_o.br_flag = cpu_exu_pkg::BR_N;
        push_data_o.br_want = 1'b1;
      end
      cpu_exu_pkg::FuncBne: begin
        push_data_o.op      = cpu_exu_pkg::OP_BRANCH;
        push_data_o.br_flag = cpu_exu_pkg::BR_Z;
        push_data_o.br_want = 1'b0;
      end
      cpu_exu_pkg::FuncBpl: begin
        push_data_o.op      = cpu_exu_pkg::OP_BRANCH;
        push_data_o.br_flag = cpu_exu_pkg::BR_N;
        push_data_o.br_want = 1'b0;
      end
      cpu_exu_pkg::FuncBvc: begin
        push_data_o.op      = cpu_exu_pkg::OP_BRANCH;
        push_data_o.br_flag = cpu_exu_pkg::BR_V;
        push_data_o.br_want = 1'b0;
      end
      cpu_exu_pkg::FuncBvs: begin
        push_data_o.op      = cpu_exu_pkg::OP_BRANCH;
        push_data_o.br_flag = cpu_exu_pkg::BR_V;
        push_data_o.br_want = 1'b1;
      end
      // Codes without an operation execute as no-ops.
      default: push_data_o.op = cpu_exu_pkg::OP_NOP;
    endcase
  end

endmodule

// File: hdl/cpu_exu_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// 6502 execute unit queue
// Small first-in first-out buffer of decoded operations between the front
// and back end, with simultaneous push and pop.
// ----------------------------------------------------------------------------
module cpu_exu_queue #(
  parameter int unsigned Depth = cpu_exu_pkg::QueueDepthDefault
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  cpu_exu_pkg::qent_t  push_data_i,
  output logic                full_o,
  input  logic                pop_i,
  output logic                valid_o,
  output cpu_exu_pkg::qent_t  head_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);

  cpu_exu_pkg::qent_t entries_q [Depth];
  logic [PtrW-1:0]    wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]    rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]    count_q, count_d;
  logic               do_push, do_pop;

  assign full_o  = (count_q == CntW'(Depth));
  assign valid_o = (count_q != '0);
  assign head_o  = entries_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  // Pointer and fill count update.
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + PtrW'(1);
    end
    if (do_push && !do_pop) begin
      count_d = count_q + CntW'(1);
    end else if (do_pop && !do_push) begin
      count_d = count_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Entry storage.
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entries_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

// File: hdl/cpu_exu_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// 6502 execute unit back end
// Holds the architectural registers, executes the operation at the head of
// the queue and drives the result register. BRK takes three beats.
// ----------------------------------------------------------------------------
module cpu_exu_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                q_valid_i,
  input  cpu_exu_pkg::qent_t  head_i,
  output logic                pop_o,
  cpu_exu_out_if.source       rsp_o
);

  localparam int unsigned DataW = cpu_exu_pkg::DataW;
  localparam int unsigned AddrW = cpu_exu_pkg::AddrW;

  // BRK push beats: return address high, return address low, status.
  localparam logic [1:0] BeatHi = 2'd0;
  localparam logic [1:0] BeatLo = 2'd1;
  localparam logic [1:0] BeatSr = 2'd2;

  // Update Z and N from a result byte.
  function automatic logic [DataW-1:0] with_zn(input logic [DataW-1:0] f,
                                               input logic [DataW-1:0] v);
    logic [DataW-1:0] r;
    r = f;
    r[cpu_exu_pkg::FlagZ] = (v == '0);
    r[cpu_exu_pkg::FlagN] = v[DataW-1];
    return r;
  endfunction

  // Architectural state.
  logic [DataW-1:0] acc_q, acc_d;
  logic [DataW-1:0] x_q, x_d;
  logic [DataW-1:0] y_q, y_d;
  logic [DataW-1:0] flags_q, flags_d;
  logic [DataW-1:0] sp_q, sp_d;
  logic [1:0]       beat_q, beat_d;
  logic [DataW-1:0] pushed_q, pushed_d;

  // Result register.
  logic             out_valid_q;
  logic             we_q, we_d;
  logic [AddrW-1:0] waddr_q, waddr_d;
  logic [DataW-1:0] wdata_q, wdata_d;
  logic             taken_q, taken_d;
  logic             vec_q, vec_d;
  logic             last_q, last_d;

  logic             exec_fire;
  logic             is_brk;
  logic [DataW:0]   sum9;
  logic [DataW:0]   diff9;
  logic             br_flag_val;
  logic [DataW-1:0] m;

  assign m         = head_i.operand;
  assign is_brk    = (head_i.op == cpu_exu_pkg::OP_BRK);
  assign exec_fire = q_valid_i && (!out_valid_q || rsp_o.ready);
  assign pop_o     = exec_fire && (!is_brk || beat_q == BeatSr);

  assign sum9  = {1'b0, acc_q} + {1'b0, m} + {{DataW{1'b0}}, flags_q[cpu_exu_pkg::FlagC]};
  assign diff9 = {1'b0, x_q} - {1'b0, m};

  // Flag tested by a branch.
  always_comb begin
    unique case (head_i.br_flag)
      cpu_exu_pkg::BR_C: br_flag_val = flags_q[cpu_exu_pkg::FlagC];
      cpu_exu_pkg::BR_Z: br_flag_val = flags_q[cpu_exu_pkg::FlagZ];
      cpu_exu_pkg::BR_N: br_flag_val = flags_q[cpu_exu_pkg::FlagN];
      cpu_exu_pkg::BR_V: br_flag_val = flags_q[cpu_exu_pkg::FlagV];
      default:           br_flag_val = 1'b0;
    endcase
  end

  // Execute the head operation.
  always_comb begin
    acc_d    = acc_q;
    x_d      = x_q;
    y_d      = y_q;
    flags_d  = flags_q;
    sp_d     = sp_q;
    beat_d   = beat_q;
    pushed_d = pushed_q;
    we_d     = 1'b0;
    waddr_d  = '0;
    wdata_d  = '0;
    taken_d  = 1'b0;
    vec_d    = 1'b0;
    last_d   = 1'b1;
    unique case (head_i.op)
      cpu_exu_pkg::OP_ADC: begin
        acc_d = sum9[DataW-1:0];
        flags_d[cpu_exu_pkg::FlagC] = sum9[DataW];
        flags_d[cpu_exu_pkg::FlagV] = ~(acc_q[DataW-1] ^ m[DataW-1])
                                      & (acc_q[DataW-1] ^ sum9[DataW-1]);
        flags_d = with_zn(flags_d, sum9[DataW-1:0]);
      end
      cpu_exu_pkg::OP_AND: begin
        acc_d   = acc_q & m;
        flags_d = with_zn(flags_q, acc_q & m);
      end
      cpu_exu_pkg::OP_ASL_MEM: begin
        we_d    = 1'b1;
        waddr_d = head_i.eff_addr;
        wdata_d = {m[DataW-2:0], 1'b0};
        flags_d[cpu_exu_pkg::FlagC] = m[DataW-1];
        flags_d = with_zn(flags_d, {m[DataW-2:0], 1'b0});
      end
      cpu_exu_pkg::OP_SHIFT_ACC: begin
        acc_d = {acc_q[DataW-2:0], 1'b0};
        flags_d[cpu_exu_pkg::FlagC] = acc_q[DataW-1];
        flags_d = with_zn(flags_d, {acc_q[DataW-2:0], 1'b0});
      end
      cpu_exu_pkg::OP_BIT: begin
        flags_d[cpu_exu_pkg::FlagN] = m[cpu_exu_pkg::FlagN];
        flags_d[cpu_exu_pkg::FlagV] = m[cpu_exu_pkg::FlagV];
        flags_d[cpu_exu_pkg::FlagZ] = ((m & acc_q) == '0);
      end
      // Unsigned compare: carry means no borrow.
      cpu_exu_pkg::OP_CPX: begin
        flags_d[cpu_exu_pkg::FlagC] = !diff9[DataW];
        flags_d[cpu_exu_pkg::FlagZ] = (x_q == m);
        flags_d[cpu_exu_pkg::FlagN] = diff9[DataW-1];
      end
      cpu_exu_pkg::OP_DEC: begin
        we_d    = 1'b1;
        waddr_d = head_i.eff_addr;
        wdata_d = m - DataW'(1);
        flags_d = with_zn(flags_q, m - DataW'(1));
      end
      cpu_exu_pkg::OP_DEX: begin
        x_d     = x_q - DataW'(1);
        flags_d = with_zn(flags_q, x_q - DataW'(1));
      end
      cpu_exu_pkg::OP_DEY: begin
        y_d     = y_q - DataW'(1);
        flags_d = with_zn(flags_q, y_q - DataW'(1));
      end
      cpu_exu_pkg::OP_LDA: begin
        acc_d   = m;
        flags_d = with_zn(flags_q, m);
      end
      cpu_exu_pkg::OP_LDX: begin
        x_d     = m;
        flags_d = with_zn(flags_q, m);
      end
      cpu_exu_pkg::OP_LDY: begin
        y_d     = m;
        flags_d = with_zn(flags_q, m);
      end
      cpu_exu_pkg::OP_STA: begin
        we_d    = 1'b1;
        waddr_d = head_i.eff_addr;
        wdata_d = acc_q;
      end
      cpu_exu_pkg::OP_STX: begin
        we_d    = 1'b1;
        waddr_d = head_i.eff_addr;
        wdata_d = x_q;
      end
      cpu_exu_pkg::OP_STY: begin
        we_d    = 1'b1;
        waddr_d = head_i.eff_addr;
        wdata_d = y_q;
      end
      // One stack write per beat; I is set on the first beat so that every
      // beat shows the final status.
      cpu_exu_pkg::OP_BRK: begin
        we_d    = 1'b1;
        vec_d   = 1'b1;
        waddr_d = {cpu_exu_pkg::StackPage, sp_q};
        sp_d    = sp_q - DataW'(1);
        last_d  = (beat_q == BeatSr);
        beat_d  = (beat_q == BeatSr) ? BeatHi : beat_q + 2'd1;
        unique case (beat_q)
          BeatHi: begin
            wdata_d  = head_i.ret_addr[AddrW-1:DataW];
            pushed_d = flags_q;
            pushed_d[cpu_exu_pkg::FlagN] = 1'b0;
            pushed_d[cpu_exu_pkg::FlagB] = 1'b1;
            flags_d[cpu_exu_pkg::FlagI]  = 1'b1;
          end
          BeatLo:  wdata_d = head_i.ret_addr[DataW-1:0];
          default: wdata_d = pushed_q;
        endcase
      end
      cpu_exu_pkg::OP_BRANCH: taken_d = (br_flag_val == head_i.br_want);
      default: ;
    endcase
  end

  // Architectural registers and BRK sequencing.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q   <= '0;
      x_q     <= '0;
      y_q     <= '0;
      flags_q <= '0;
      sp_q    <= cpu_exu_pkg::SpReset;
      beat_q  <= BeatHi;
    end else if (exec_fire) begin
      acc_q   <= acc_d;
      x_q     <= x_d;
      y_q     <= y_d;
      flags_q <= flags_d;
      sp_q    <= sp_d;
      beat_q  <= beat_d;
    end
  end

  // Result valid flag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (exec_fire) begin
      out_valid_q <= 1'b1;
    end else if (rsp_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  // Result payload and saved BRK status.
  always_ff @(posedge clk_i) begin
    if (exec_fire) begin
      we_q     <= we_d;
      waddr_q  <= waddr_d;
      wdata_q  <= wdata_d;
      taken_q  <= taken_d;
      vec_q    <= vec_d;
      last_q   <= last_d;
      pushed_q <= pushed_d;
    end
  end

  // Register values shown are those after the operation in the result register.
  assign rsp_o.valid        = out_valid_q;
  assign rsp_o.write_enable = we_q;
  assign rsp_o.write_addr   = waddr_q;
  assign rsp_o.write_data   = wdata_q;
  assign rsp_o.acc_value    = acc_q;
  assign rsp_o.x_value      = x_q;
  assign rsp_o.y_value      = y_q;
  assign rsp_o.flags_value  = flags_q;
  assign rsp_o.branch_taken = taken_q;
  assign rsp_o.vector_fetch = vec_q;
  assign rsp_o.last         = last_q;

  // A BRK in progress keeps its entry at the head of the queue.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (beat_q != BeatHi) |-> (q_valid_i && is_brk))
    else $error("BRK sequence lost its queue entry");

  // The first BRK beat is followed by the second.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (exec_fire && is_brk && beat_q == BeatHi) |=> (beat_q == BeatLo))
    else $error("BRK beat counter did not advance");

  // Every BRK beat pushes one byte and moves the stack pointer down by one.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (exec_fire && is_brk) |=> (sp_q == $past(sp_q) - DataW'(1)))
    else $error("Stack pointer not decremented on BRK push");

  // The final BRK result shows the interrupt disable flag set.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && vec_q && last_q) |-> flags_q[cpu_exu_pkg::FlagI])
    else $error("BRK completed without setting I");

endmodule

// File: hdl/cpu6502_execute_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// 6502 execute unit
// Executes decoded 6502 operations against A, X, Y, S and the status flags.
// ----------------------------------------------------------------------------
// Usage:
// Requests arrive on req_i (valid/ready) carrying the operation code, the
// operand byte, the effective address and the pc after opcode fetch. Each
// request yields one result on rsp_o, or three for BRK (the stack pushes of
// the return address high and low byte and the status), with last marking
// the final result of a request.
// A taken request is written into the queue and executed from there into the result register.
// Throughput: one request per cycle while rsp_o is not stalled; BRK holds the
// execute stage until its three results are out, since the result register
// carries one memory write per cycle.
// The front end decodes requests into a queue of QueueDepth entries; the back
// end executes from the queue into a result register. When the receiver
// stalls, the result register holds, the queue fills and req_i.ready drops
// once it is full.
// Reset clears A, X, Y and the flags, sets the stack pointer to 0xFF and
// empties the queue and the result register; no setup is needed.
// ----------------------------------------------------------------------------
module cpu6502_execute_unit #(
  parameter int unsigned QueueDepth = cpu_exu_pkg::QueueDepthDefault
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  cpu_exu_in_if.sink    req_i,
  cpu_exu_out_if.source rsp_o
);

  logic               push;
  logic               full;
  logic               pop;
  logic               q_valid;
  cpu_exu_pkg::qent_t push_data;
  cpu_exu_pkg::qent_t head;

  // Request decode.
  cpu_exu_front u_front (
    .req_i       (req_i),
    .full_i      (full),
    .push_o      (push),
    .push_data_o (push_data)
  );

  // Decoupling queue.
  cpu_exu_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .full_o      (full),
    .pop_i       (pop),
    .valid_o     (q_valid),
    .head_o      (head)
  );

  // Execution and result register.
  cpu_exu_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .q_valid_i (q_valid),
    .head_i    (head),
    .pop_o     (pop),
    .rsp_o     (rsp_o)
  );

endmodule
